// ===== sv/sprite_screen_projection_unit_defines.svh =====
// Assertion macros shared by the sprite projection RTL.
// Needs clk_i and rst_ni in the scope of every use.
`ifndef SPRITE_SCREEN_PROJECTION_UNIT_DEFINES_SVH
`define SPRITE_SCREEN_PROJECTION_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define SSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define SSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ssp_pkg.sv =====
// Shared types, widths and register codes of the sprite projection unit.
// No dependencies.
`default_nettype none

package ssp_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int FIFO_DEPTH_DEF = 4;

  localparam int IDX_W   = 3;
  localparam int DATA_W  = 26;
  localparam int DIM_W   = 13;
  localparam int HDIM_W  = 12;
  localparam int POS_W   = 26;
  localparam int VEC_W   = 18;
  localparam int OFS_W   = 27;
  localparam int PRD_W   = 45;
  localparam int NUM_W   = 46;
  localparam int DPRD_W  = 36;
  localparam int DET_W   = 37;
  localparam int QUO_W   = 48;
  localparam int SUM_W   = 50;
  localparam int SMAG_W  = 49;
  localparam int PROD_W  = 61;

  // Register indexes of the configuration port
  typedef enum logic [IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_CAMERA_X      = 3'd2,
    REG_CAMERA_Y      = 3'd3,
    REG_DIR_X         = 3'd4,
    REG_DIR_Y         = 3'd5,
    REG_PLANE_X       = 3'd6,
    REG_PLANE_Y       = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic        [DIM_W-1:0] screen_width;
    logic        [DIM_W-1:0] screen_height;
    logic signed [POS_W-1:0] camera_x;
    logic signed [POS_W-1:0] camera_y;
    logic signed [VEC_W-1:0] dir_x;
    logic signed [VEC_W-1:0] dir_y;
    logic signed [VEC_W-1:0] plane_x;
    logic signed [VEC_W-1:0] plane_y;
  } cfg_t;

  // Word handed from front to back
  typedef struct packed {
    logic signed [NUM_W-1:0] num_lat;
    logic signed [NUM_W-1:0] num_dep;
    logic signed [DET_W-1:0] det;
    logic                    det_zero;
  } qent_t;

endpackage

`default_nettype wire

// ===== sv/sprite_screen_projection_unit.sv =====
// Sprite screen projection: one sprite map position in, one depth/column/size/rectangle word
// out. Fully pipelined: a new sprite word can be taken every cycle and results leave one per
// cycle while neither side stalls. The pipeline is dominated by the two bit-per-stage divider
// pipelines: 49 registers for lateral/depth (input register plus 48 quotient bits) and
// FRAC_BITS + 15 for column/size, plus three front stages, the queue, two back stages and the
// output register. A four-word queue separates the front from the back so each side stalls on
// its own. Configuration writes are taken every cycle; the user must write them only while
// no word is in flight, as the block itself does not enforce this.
`default_nettype none

module sprite_screen_projection_unit #(
  parameter int FRAC_BITS  = ssp_pkg::FRAC_BITS_DEF,
  parameter int FIFO_DEPTH = ssp_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [ssp_pkg::IDX_W-1:0]         cfg_index_i,
  input  wire logic [ssp_pkg::DATA_W-1:0]        cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [ssp_pkg::POS_W-1:0]  sprite_x_i,
  input  wire logic signed [ssp_pkg::POS_W-1:0]  sprite_y_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [25:0]                     depth_o,
  output logic signed [15:0]                     screen_column_o,
  output logic        [15:0]                     size_o,
  output logic        [11:0]                     top_row_o,
  output logic        [11:0]                     bottom_row_o,
  output logic        [14:0]                     left_column_o,
  output logic signed [15:0]                     right_column_o,
  output logic                                   degenerate_o
);

  ssp_pkg::cfg_t  cfg_q;
  ssp_pkg::qent_t push_data, head;
  logic           push, full, pop, empty;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width  <= 13'd640;
      cfg_q.screen_height <= 13'd480;
      cfg_q.camera_x      <= '0;
      cfg_q.camera_y      <= '0;
      cfg_q.dir_x         <= -18'sd65536;
      cfg_q.dir_y         <= '0;
      cfg_q.plane_x       <= '0;
      cfg_q.plane_y       <= 18'sd43254;
    end else if (cfg_valid_i) begin
      unique case (ssp_pkg::reg_idx_e'(cfg_index_i))
        ssp_pkg::REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data_i[12:0];
        ssp_pkg::REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data_i[12:0];
        ssp_pkg::REG_CAMERA_X:      cfg_q.camera_x      <= signed'(cfg_data_i[25:0]);
        ssp_pkg::REG_CAMERA_Y:      cfg_q.camera_y      <= signed'(cfg_data_i[25:0]);
        ssp_pkg::REG_DIR_X:         cfg_q.dir_x         <= signed'(cfg_data_i[17:0]);
        ssp_pkg::REG_DIR_Y:         cfg_q.dir_y         <= signed'(cfg_data_i[17:0]);
        ssp_pkg::REG_PLANE_X:       cfg_q.plane_x       <= signed'(cfg_data_i[17:0]);
        ssp_pkg::REG_PLANE_Y:       cfg_q.plane_y       <= signed'(cfg_data_i[17:0]);
        default:                    cfg_q               <= cfg_q;
      endcase
    end
  end

  ssp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .sprite_x_i  (sprite_x_i),
    .sprite_y_i  (sprite_y_i),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  ssp_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (head),
    .empty_o (empty)
  );

  ssp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .head_i          (head),
    .empty_i         (empty),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .depth_o         (depth_o),
    .screen_column_o (screen_column_o),
    .size_o          (size_o),
    .top_row_o       (top_row_o),
    .bottom_row_o    (bottom_row_o),
    .left_column_o   (left_column_o),
    .right_column_o  (right_column_o),
    .degenerate_o    (degenerate_o)
  );

endmodule

`default_nettype wire

// ===== sv/ssp_front.sv =====
// Front end: takes sprite words, forms camera offsets, products and numerators.
// Uses ssp_pkg.
`default_nettype none

module ssp_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire ssp_pkg::cfg_t                     cfg_i,
  input  wire logic                              in_valid_i,
  input  wire logic signed [ssp_pkg::POS_W-1:0]  sprite_x_i,
  input  wire logic signed [ssp_pkg::POS_W-1:0]  sprite_y_i,
  output logic                                   in_stall_o,
  output logic                                   push_o,
  output ssp_pkg::qent_t                         push_data_o,
  input  wire logic                              full_i
);

  logic adv;
  logic v1_q, v2_q, v3_q;

  logic signed [ssp_pkg::OFS_W-1:0]  rx_q, ry_q, rx_d, ry_d;
  logic signed [ssp_pkg::PRD_W-1:0]  dyrx_q, dxry_q, pxry_q, pyrx_q;
  logic signed [ssp_pkg::PRD_W-1:0]  dyrx_d, dxry_d, pxry_d, pyrx_d;
  logic signed [ssp_pkg::DPRD_W-1:0] pxdy_q, dxpy_q, pxdy_d, dxpy_d;
  ssp_pkg::qent_t                    ent_q, ent_d;

  // whole front moves unless the last stage is blocked by a full queue
  assign adv        = !v3_q || !full_i;
  assign in_stall_o = !adv;
  assign push_o     = v3_q && !full_i;
  assign push_data_o = ent_q;

  // offsets from the camera
  assign rx_d = ssp_pkg::OFS_W'(sprite_x_i) - ssp_pkg::OFS_W'(cfg_i.camera_x);
  assign ry_d = ssp_pkg::OFS_W'(sprite_y_i) - ssp_pkg::OFS_W'(cfg_i.camera_y);

  // inverse camera matrix products, one multiplier each
  assign dyrx_d = cfg_i.dir_y * rx_q;
  assign dxry_d = cfg_i.dir_x * ry_q;
  assign pxry_d = cfg_i.plane_x * ry_q;
  assign pyrx_d = cfg_i.plane_y * rx_q;
  assign pxdy_d = cfg_i.plane_x * cfg_i.dir_y;
  assign dxpy_d = cfg_i.dir_x * cfg_i.plane_y;

  // numerators and determinant, flag a singular camera
  always_comb begin
    ent_d.num_lat  = ssp_pkg::NUM_W'(dyrx_q) - ssp_pkg::NUM_W'(dxry_q);
    ent_d.num_dep  = ssp_pkg::NUM_W'(pxry_q) - ssp_pkg::NUM_W'(pyrx_q);
    ent_d.det      = ssp_pkg::DET_W'(pxdy_q) - ssp_pkg::DET_W'(dxpy_q);
    ent_d.det_zero = (pxdy_q == dxpy_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rx_q   <= rx_d;
      ry_q   <= ry_d;
      dyrx_q <= dyrx_d;
      dxry_q <= dxry_d;
      pxry_q <= pxry_d;
      pyrx_q <= pyrx_d;
      pxdy_q <= pxdy_d;
      dxpy_q <= dxpy_d;
      ent_q  <= ent_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ssp_fifo.sv =====
// Short queue of classified words between front and back.
// Uses ssp_pkg and the assertion macros header.
`default_nettype none
`include "sprite_screen_projection_unit_defines.svh"

module ssp_fifo #(
  parameter int DEPTH = ssp_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire ssp_pkg::qent_t wdata_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output ssp_pkg::qent_t      rdata_o,
  output logic                empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ssp_pkg::qent_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  `SSP_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(DEPTH), "queue count above depth")
  `SSP_ASSERT_NOW(a_no_pop_empty, pop_i, !empty_o, "pop from empty queue")
  `SSP_ASSERT_NEXT(a_cnt_up, push_i && !pop_i, cnt_q == $past(cnt_q) + CNT_W'(1), "count did not rise")

endmodule

`default_nettype wire

// ===== sv/ssp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, saturating quotient.
// No package dependency.
`default_nettype none

module ssp_div #(
  parameter int NUM_W = 62,
  parameter int DEN_W = 37,
  parameter int QUO_W = 48,
  parameter int TAG_W = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  input  wire logic [TAG_W-1:0] tag_i,
  output logic                  valid_o,
  output logic [QUO_W-1:0]      quo_o,
  output logic [TAG_W-1:0]      tag_o
);

  localparam int HI_W = NUM_W - QUO_W;
  localparam int CW   = (HI_W > DEN_W) ? HI_W : DEN_W;

  logic             vld_q [QUO_W+1];
  logic             ovf_q [QUO_W+1];
  logic [DEN_W-1:0] rem_q [QUO_W+1];
  logic [QUO_W-1:0] sh_q  [QUO_W+1];
  logic [DEN_W-1:0] den_q [QUO_W+1];
  logic [TAG_W-1:0] tag_q [QUO_W+1];

  logic [DEN_W-1:0] rem_nx [QUO_W];
  logic [QUO_W-1:0] sh_nx  [QUO_W];
  logic [DEN_W:0]   trial  [QUO_W];
  logic [DEN_W:0]   diff   [QUO_W];
  logic [HI_W-1:0]  hi;
  logic             ovf0;

  // entry: quotient would not fit when the high part already reaches the divisor
  assign hi   = num_i[NUM_W-1:QUO_W];
  assign ovf0 = CW'(hi) >= CW'(den_i);

  // one shift-and-subtract per stage
  always_comb begin
    for (int i = 0; i < QUO_W; i++) begin
      trial[i]  = {rem_q[i], sh_q[i][QUO_W-1]};
      diff[i]   = trial[i] - {1'b0, den_q[i]};
      if (trial[i] >= {1'b0, den_q[i]}) begin
        rem_nx[i] = diff[i][DEN_W-1:0];
        sh_nx[i]  = {sh_q[i][QUO_W-2:0], 1'b1};
      end else begin
        rem_nx[i] = trial[i][DEN_W-1:0];
        sh_nx[i]  = {sh_q[i][QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= QUO_W; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int i = 0; i < QUO_W; i++) begin
        vld_q[i+1] <= vld_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0] <= ovf0;
      rem_q[0] <= ovf0 ? '0 : DEN_W'(hi);
      sh_q[0]  <= num_i[QUO_W-1:0];
      den_q[0] <= den_i;
      tag_q[0] <= tag_i;
      for (int i = 0; i < QUO_W; i++) begin
        ovf_q[i+1] <= ovf_q[i];
        rem_q[i+1] <= rem_nx[i];
        sh_q[i+1]  <= sh_nx[i];
        den_q[i+1] <= den_q[i];
        tag_q[i+1] <= tag_q[i];
      end
    end
  end

  assign valid_o = vld_q[QUO_W];
  assign quo_o   = ovf_q[QUO_W] ? '1 : sh_q[QUO_W];
  assign tag_o   = tag_q[QUO_W];

endmodule

`default_nettype wire

// ===== sv/ssp_back.sv =====
// Back end: divisions, screen column, size and clipped rectangle, output register.
// Uses ssp_pkg, ssp_div and the assertion macros header.
`default_nettype none
`include "sprite_screen_projection_unit_defines.svh"

module ssp_back #(
  parameter int FRAC_BITS = ssp_pkg::FRAC_BITS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ssp_pkg::cfg_t  cfg_i,
  input  wire ssp_pkg::qent_t head_i,
  input  wire logic           empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic signed [25:0]  depth_o,
  output logic signed [15:0]  screen_column_o,
  output logic        [15:0]  size_o,
  output logic        [11:0]  top_row_o,
  output logic        [11:0]  bottom_row_o,
  output logic        [14:0]  left_column_o,
  output logic signed [15:0]  right_column_o,
  output logic                degenerate_o
);

  localparam int NW   = ssp_pkg::NUM_W;
  localparam int NL_W = NW + FRAC_BITS;
  localparam int QW   = ssp_pkg::QUO_W;
  localparam int QC   = FRAC_BITS + 14;
  localparam int NS_W = QC + 1;
  localparam int SW   = QC + 3;
  localparam int DW   = ssp_pkg::DET_W;
  localparam int UW   = ssp_pkg::SUM_W;

  logic adv;

  // ---- first divisions: lateral offset and depth over the determinant
  logic [NW-1:0]  lat_mag, dep_mag_n;
  logic [DW-1:0]  det_mag;
  logic           lat_v, dep_v;
  logic [QW-1:0]  q_lat, q_dep;
  logic [0:0]     t_lat;
  logic [1:0]     t_dep;

  assign adv   = !out_valid_o || !out_stall_i;
  assign pop_o = adv && !empty_i;

  assign lat_mag   = head_i.num_lat[NW-1] ? NW'(-head_i.num_lat) : NW'(head_i.num_lat);
  assign dep_mag_n = head_i.num_dep[NW-1] ? NW'(-head_i.num_dep) : NW'(head_i.num_dep);
  assign det_mag   = head_i.det[DW-1] ? DW'(-head_i.det) : DW'(head_i.det);

  ssp_div #(.NUM_W(NL_W), .DEN_W(DW), .QUO_W(QW), .TAG_W(1)) u_div_lat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (!empty_i),
    .num_i   ({lat_mag, {FRAC_BITS{1'b0}}}),
    .den_i   (det_mag),
    .tag_i   (head_i.num_lat[NW-1] ^ head_i.det[DW-1]),
    .valid_o (lat_v),
    .quo_o   (q_lat),
    .tag_o   (t_lat)
  );

  ssp_div #(.NUM_W(NL_W), .DEN_W(DW), .QUO_W(QW), .TAG_W(2)) u_div_dep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (!empty_i),
    .num_i   ({dep_mag_n, {FRAC_BITS{1'b0}}}),
    .den_i   (det_mag),
    .tag_i   ({head_i.det_zero, head_i.num_dep[NW-1] ^ head_i.det[DW-1]}),
    .valid_o (dep_v),
    .quo_o   (q_dep),
    .tag_o   (t_dep)
  );

  // ---- stage M1: signed sum, depth saturation, degenerate flag
  logic signed [UW-1:0] lat_s, dep_s, sum_s;
  logic [ssp_pkg::SMAG_W-1:0] smag_d, m1_smag_q;
  logic signed [25:0] depth_d, m1_depth_q;
  logic m1_v_q, m1_deg_q, m1_cneg_q;
  logic [QW-1:0] m1_dmag_q;

  always_comb begin
    lat_s = t_lat[0] ? -signed'(UW'(q_lat)) : signed'(UW'(q_lat));
    dep_s = t_dep[0] ? -signed'(UW'(q_dep)) : signed'(UW'(q_dep));
    sum_s = lat_s + dep_s;
    smag_d = sum_s[UW-1] ? ssp_pkg::SMAG_W'(-sum_s) : ssp_pkg::SMAG_W'(sum_s);
    if (t_dep[0]) begin
      depth_d = (q_dep > QW'(33554432)) ? 26'sh2000000 : -signed'(26'(q_dep));
    end else begin
      depth_d = (q_dep > QW'(33554431)) ? 26'sh1FFFFFF : signed'(26'(q_dep));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
    end else if (adv) begin
      m1_v_q <= dep_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_deg_q   <= t_dep[1] || (q_dep == '0);
      m1_cneg_q  <= sum_s[UW-1] ^ t_dep[0];
      m1_smag_q  <= smag_d;
      m1_dmag_q  <= q_dep;
      m1_depth_q <= depth_d;
    end
  end

  // ---- stage M2: column numerator (half width times sum)
  logic m2_v_q, m2_deg_q, m2_cneg_q;
  logic [ssp_pkg::PROD_W-1:0] m2_prod_q, prod_d;
  logic [QW-1:0] m2_dmag_q;
  logic signed [25:0] m2_depth_q;

  assign prod_d = cfg_i.screen_width[ssp_pkg::DIM_W-1:1] * m1_smag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_v_q <= 1'b0;
    end else if (adv) begin
      m2_v_q <= m1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m2_deg_q   <= m1_deg_q;
      m2_cneg_q  <= m1_cneg_q;
      m2_prod_q  <= prod_d;
      m2_dmag_q  <= m1_dmag_q;
      m2_depth_q <= m1_depth_q;
    end
  end

  // ---- second divisions: column and size over |depth|
  logic          col_v, size_v;
  logic [QC-1:0] q_col, q_size;
  logic [1:0]    t_col;
  logic [25:0]   t_size;

  ssp_div #(.NUM_W(ssp_pkg::PROD_W), .DEN_W(QW), .QUO_W(QC), .TAG_W(2)) u_div_col (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (m2_v_q),
    .num_i   (m2_prod_q),
    .den_i   (m2_dmag_q),
    .tag_i   ({m2_deg_q, m2_cneg_q}),
    .valid_o (col_v),
    .quo_o   (q_col),
    .tag_o   (t_col)
  );

  ssp_div #(.NUM_W(NS_W), .DEN_W(QW), .QUO_W(QC), .TAG_W(26)) u_div_size (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (m2_v_q),
    .num_i   (NS_W'({cfg_i.screen_height, {FRAC_BITS{1'b0}}})),
    .den_i   (m2_dmag_q),
    .tag_i   (m2_depth_q),
    .valid_o (size_v),
    .quo_o   (q_size),
    .tag_o   (t_size)
  );

  // ---- rectangle, clipping and saturation into the output register
  logic signed [SW-1:0] col_s, size_s, half_s, h_s, h2_s, w_s;
  logic signed [SW-1:0] top_s, bot_s, left_s, right_s;
  logic signed [25:0] depth_d2;
  logic signed [15:0] scol_d, right_d;
  logic [15:0] size_d;
  logic [11:0] top_d, bot_d;
  logic [14:0] left_d;

  logic               out_v_q, deg_q;
  logic signed [25:0] depth_q;
  logic signed [15:0] scol_q, right_q;
  logic [15:0]        size_q;
  logic [11:0]        top_q, bot_q;
  logic [14:0]        left_q;

  always_comb begin
    col_s  = t_col[0] ? -signed'(SW'(q_col)) : signed'(SW'(q_col));
    size_s = signed'(SW'(q_size));
    half_s = size_s >>> 1;
    h_s    = signed'(SW'(cfg_i.screen_height));
    w_s    = signed'(SW'(cfg_i.screen_width));
    h2_s   = h_s >>> 1;

    top_s = h2_s - half_s;
    bot_s = half_s + h2_s;
    if (bot_s >= h_s) begin
      bot_s = h_s - SW'(1);
    end
    left_s  = col_s - half_s;
    right_s = half_s + col_s;
    if (right_s >= w_s) begin
      right_s = w_s - SW'(1);
    end

    priority if (top_s < SW'(0))     top_d = '0;
    else if (top_s > SW'(4095))      top_d = 12'd4095;
    else                             top_d = top_s[11:0];

    priority if (bot_s < SW'(0))     bot_d = '0;
    else if (bot_s > SW'(4095))      bot_d = 12'd4095;
    else                             bot_d = bot_s[11:0];

    priority if (left_s < SW'(0))    left_d = '0;
    else if (left_s > SW'(32767))    left_d = 15'h7FFF;
    else                             left_d = left_s[14:0];

    priority if (right_s < SW'(-32768)) right_d = 16'sh8000;
    else if (right_s > SW'(32767))      right_d = 16'sh7FFF;
    else                                right_d = right_s[15:0];

    priority if (col_s < SW'(-32768)) scol_d = 16'sh8000;
    else if (col_s > SW'(32767))      scol_d = 16'sh7FFF;
    else                              scol_d = col_s[15:0];

    size_d   = (size_s > SW'(65535)) ? 16'hFFFF : size_s[15:0];
    depth_d2 = signed'(t_size);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= col_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      deg_q <= t_col[1];
      if (t_col[1]) begin
        depth_q <= '0;
        scol_q  <= '0;
        size_q  <= '0;
        top_q   <= '0;
        bot_q   <= '0;
        left_q  <= '0;
        right_q <= '0;
      end else begin
        depth_q <= depth_d2;
        scol_q  <= scol_d;
        size_q  <= size_d;
        top_q   <= top_d;
        bot_q   <= bot_d;
        left_q  <= left_d;
        right_q <= right_d;
      end
    end
  end

  assign out_valid_o     = out_v_q;
  assign degenerate_o    = deg_q;
  assign depth_o         = depth_q;
  assign screen_column_o = scol_q;
  assign size_o          = size_q;
  assign top_row_o       = top_q;
  assign bottom_row_o    = bot_q;
  assign left_column_o   = left_q;
  assign right_column_o  = right_q;

  `SSP_ASSERT_NOW(a_lat_dep_step, 1'b1, lat_v == dep_v, "lateral and depth dividers out of step")
  `SSP_ASSERT_NOW(a_col_size_step, 1'b1, col_v == size_v, "column and size dividers out of step")
  `SSP_ASSERT_NOW(a_degen_zero, out_v_q && deg_q, (size_q == '0) && (depth_q == '0) && (right_q == '0), "degenerate word carries data")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for sprite_screen_projection_unit: random and directed sprite words,
// several camera/screen settings, every result checked against an in-bench projection model.
// Depends on ssp_pkg and the unit RTL.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

  localparam int FB = ssp_pkg::FRAC_BITS_DEF;
  localparam longint unsigned QCAP = 64'hFFFF_FFFF_FFFF;
  localparam int WDOG_LIMIT = 20000;
  localparam int HOLD_LEN = 400;

  typedef struct packed {
    logic signed [25:0] depth;
    logic signed [15:0] screen_column;
    logic        [15:0] size;
    logic        [11:0] top_row;
    logic        [11:0] bottom_row;
    logic        [14:0] left_column;
    logic signed [15:0] right_column;
    logic               degenerate;
  } proj_t;

  typedef struct packed {
    logic signed [ssp_pkg::POS_W-1:0] sx;
    logic signed [ssp_pkg::POS_W-1:0] sy;
  } sprite_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [ssp_pkg::IDX_W-1:0] cfg_index_i = '0;
  logic [ssp_pkg::DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [ssp_pkg::POS_W-1:0] sprite_x_i = '0;
  logic signed [ssp_pkg::POS_W-1:0] sprite_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  proj_t act;

  sprite_screen_projection_unit DUT (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .sprite_x_i, .sprite_y_i, .out_valid_o, .out_stall_i,
    .depth_o(act.depth), .screen_column_o(act.screen_column), .size_o(act.size),
    .top_row_o(act.top_row), .bottom_row_o(act.bottom_row),
    .left_column_o(act.left_column), .right_column_o(act.right_column),
    .degenerate_o(act.degenerate)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the camera and screen registers
  logic        [ssp_pkg::DIM_W-1:0] sh_w = 13'd640;
  logic        [ssp_pkg::DIM_W-1:0] sh_h = 13'd480;
  logic signed [ssp_pkg::POS_W-1:0] sh_cx = '0;
  logic signed [ssp_pkg::POS_W-1:0] sh_cy = '0;
  logic signed [ssp_pkg::VEC_W-1:0] sh_dx = -18'sd65536;
  logic signed [ssp_pkg::VEC_W-1:0] sh_dy = '0;
  logic signed [ssp_pkg::VEC_W-1:0] sh_px = '0;
  logic signed [ssp_pkg::VEC_W-1:0] sh_py = 18'sd43254;

  sprite_t pending_sprites[$];
  proj_t   expected_proj[$];
  bit      idle_on = 1'b1;
  bit      hold_go = 1'b0;
  int      hold_left = 0;
  int      errors = 0;
  int      n_sent = 0;
  int      n_checked = 0;
  int      n_degen = 0;
  int      wdog = 0;

  function automatic longint unsigned magn(longint v);
    return (v < 0) ? longint'(0) - v : v;
  endfunction

  // (num << FB) / den toward zero, magnitude capped
  function automatic longint fixed_quot(longint num, longint den);
    longint unsigned n, d, q, r;
    bit neg;
    n = magn(num);
    d = magn(den);
    neg = (num < 0) != (den < 0);
    q = n / d;
    r = n % d;
    if (q > (QCAP >> FB)) q = QCAP;
    else begin
      for (int i = 0; i < FB; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= d) begin
          r = r - d;
          q = q | 64'd1;
        end
      end
      if (q > QCAP) q = QCAP;
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic proj_t project_sprite(sprite_t s);
    proj_t p;
    longint dx, dy, px, py, rx, ry, w, h, det, lat, dep, col, sz, half, top, bot, lft, rgt;
    p = '0;
    dx = sh_dx; dy = sh_dy; px = sh_px; py = sh_py;
    rx = longint'(s.sx) - longint'(sh_cx);
    ry = longint'(s.sy) - longint'(sh_cy);
    w = longint'(sh_w);
    h = longint'(sh_h);
    det = px * dy - dx * py;
    if (det == 0) begin
      p.degenerate = 1'b1;
      return p;
    end
    lat = fixed_quot(dy * rx - dx * ry, det);
    dep = fixed_quot(px * ry - py * rx, det);
    if (dep == 0) begin
      p.degenerate = 1'b1;
      return p;
    end
    col = ((w / 2) * (lat + dep)) / dep;
    sz = longint'((longint'(h) << FB) / magn(dep));
    half = sz / 2;
    top = h / 2 - half;
    if (top < 0) top = 0;
    bot = half + h / 2;
    if (bot >= h) bot = h - 1;
    lft = col - half;
    if (lft < 0) lft = 0;
    rgt = half + col;
    if (rgt >= w) rgt = w - 1;
    p.depth = 26'(clip(dep, -33554432, 33554431));
    p.screen_column = 16'(clip(col, -32768, 32767));
    p.size = 16'(clip(sz, 0, 65535));
    p.top_row = 12'(clip(top, 0, 4095));
    p.bottom_row = 12'(clip(bot, 0, 4095));
    p.left_column = 15'(clip(lft, 0, 32767));
    p.right_column = 16'(clip(rgt, -32768, 32767));
    return p;
  endfunction

  // Register writes land in the shadow copy
  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (ssp_pkg::reg_idx_e'(cfg_index_i))
        ssp_pkg::REG_SCREEN_WIDTH:  sh_w  <= cfg_data_i[ssp_pkg::DIM_W-1:0];
        ssp_pkg::REG_SCREEN_HEIGHT: sh_h  <= cfg_data_i[ssp_pkg::DIM_W-1:0];
        ssp_pkg::REG_CAMERA_X:      sh_cx <= cfg_data_i[ssp_pkg::POS_W-1:0];
        ssp_pkg::REG_CAMERA_Y:      sh_cy <= cfg_data_i[ssp_pkg::POS_W-1:0];
        ssp_pkg::REG_DIR_X:         sh_dx <= cfg_data_i[ssp_pkg::VEC_W-1:0];
        ssp_pkg::REG_DIR_Y:         sh_dy <= cfg_data_i[ssp_pkg::VEC_W-1:0];
        ssp_pkg::REG_PLANE_X:       sh_px <= cfg_data_i[ssp_pkg::VEC_W-1:0];
        ssp_pkg::REG_PLANE_Y:       sh_py <= cfg_data_i[ssp_pkg::VEC_W-1:0];
        default: ;
      endcase
    end
  end

  // Sprite word driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_proj.push_back(project_sprite('{sx: sprite_x_i, sy: sprite_y_i}));
        n_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_sprites.size() > 0 && !(idle_on && $urandom_range(0, 99) < 25)) begin
          sprite_t s;
          s = pending_sprites.pop_front();
          sprite_x_i <= s.sx;
          sprite_y_i <= s.sy;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_proj.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          proj_t e;
          e = expected_proj.pop_front();
          n_checked++;
          if (e.degenerate) n_degen++;
          if (act.depth !== e.depth) begin
            $error("depth exp %0d got %0d", e.depth, act.depth); errors++;
          end
          if (act.screen_column !== e.screen_column) begin
            $error("screen_column exp %0d got %0d", e.screen_column, act.screen_column);
            errors++;
          end
          if (act.size !== e.size) begin
            $error("size exp %0d got %0d", e.size, act.size); errors++;
          end
          if (act.top_row !== e.top_row) begin
            $error("top_row exp %0d got %0d", e.top_row, act.top_row); errors++;
          end
          if (act.bottom_row !== e.bottom_row) begin
            $error("bottom_row exp %0d got %0d", e.bottom_row, act.bottom_row); errors++;
          end
          if (act.left_column !== e.left_column) begin
            $error("left_column exp %0d got %0d", e.left_column, act.left_column); errors++;
          end
          if (act.right_column !== e.right_column) begin
            $error("right_column exp %0d got %0d", e.right_column, act.right_column);
            errors++;
          end
          if (act.degenerate !== e.degenerate) begin
            $error("degenerate exp %0d got %0d", e.degenerate, act.degenerate); errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (hold_go) begin
        hold_go <= 1'b0;
        hold_left <= HOLD_LEN;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= idle_on && ($urandom_range(0, 99) < 25);
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      wdog <= 0;
    else if (wdog >= WDOG_LIMIT) begin
      $display("watchdog expired, no handshake for %0d cycles", WDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else wdog <= wdog + 1;
  end

  // Valid stays high across back-to-back writes; set_camera drops it after the last one
  task automatic write_reg(ssp_pkg::reg_idx_e idx, logic [ssp_pkg::DATA_W-1:0] val);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_camera(int w, int h, int cx, int cy, int dx, int dy, int px, int py);
    write_reg(ssp_pkg::REG_SCREEN_WIDTH, ssp_pkg::DATA_W'(w));
    write_reg(ssp_pkg::REG_SCREEN_HEIGHT, ssp_pkg::DATA_W'(h));
    write_reg(ssp_pkg::REG_CAMERA_X, ssp_pkg::DATA_W'(cx));
    write_reg(ssp_pkg::REG_CAMERA_Y, ssp_pkg::DATA_W'(cy));
    write_reg(ssp_pkg::REG_DIR_X, ssp_pkg::DATA_W'(dx));
    write_reg(ssp_pkg::REG_DIR_Y, ssp_pkg::DATA_W'(dy));
    write_reg(ssp_pkg::REG_PLANE_X, ssp_pkg::DATA_W'(px));
    write_reg(ssp_pkg::REG_PLANE_Y, ssp_pkg::DATA_W'(py));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending_sprites.size() > 0 || in_valid_i || expected_proj.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // Sprites mostly near the camera, some anywhere on the map
  task automatic queue_random(int n);
    sprite_t s;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 80) begin
        s.sx = ssp_pkg::POS_W'(sh_cx + $signed($urandom_range(0, 32 << FB)) - (16 << FB));
        s.sy = ssp_pkg::POS_W'(sh_cy + $signed($urandom_range(0, 32 << FB)) - (16 << FB));
      end else if ($urandom_range(0, 9) < 2) begin
        s.sx = ssp_pkg::POS_W'(sh_cx + $signed($urandom_range(0, 64)) - 32);
        s.sy = ssp_pkg::POS_W'(sh_cy + $signed($urandom_range(0, 64)) - 32);
      end else begin
        s.sx = ssp_pkg::POS_W'($urandom);
        s.sy = ssp_pkg::POS_W'($urandom);
      end
      pending_sprites.push_back(s);
    end
  endtask

  task automatic queue_one(int x, int y);
    pending_sprites.push_back('{sx: ssp_pkg::POS_W'(x), sy: ssp_pkg::POS_W'(y)});
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at reset settings
    queue_one(33554431, 33554431);
    queue_one(-33554432, -33554432);
    queue_one(33554431, -33554432);
    queue_one(-33554432, 33554431);
    queue_one(0, 0);
    queue_one(5 << FB, 0);
    queue_one(-(5 << FB), 0);
    queue_one(-(1 << FB), 1 << FB);
    queue_one(-1, 0);
    queue_one(-(1 << FB), -(3 << FB));
    queue_one(-(40 << FB), 7 << FB);
    queue_one(0, 1);
    drain();

    // Degenerate camera: direction parallel to plane
    set_camera(640, 480, 0, 0, 65536, 0, 65536, 0);
    queue_one(3 << FB, 2 << FB);
    queue_one(-33554432, 33554431);
    drain();

    // Extremes of every register
    set_camera(4096, 4096, 33554431, -33554432, 131071, -131072, -131072, 131071);
    queue_one(33554431, -33554432);
    queue_one(-33554432, 33554431);
    queue_random(150);
    drain();
    set_camera(8191, 8191, -33554432, 33554431, -131072, 131071, 131071, -131072);
    queue_random(150);
    drain();

    // Zero and unit screen sizes
    set_camera(0, 0, 0, 0, -65536, 0, 0, 43254);
    queue_one(-(1 << FB), 0);
    queue_random(100);
    drain();
    set_camera(1, 1, 2 << FB, 3 << FB, 0, 65536, 43254, 0);
    queue_random(100);
    drain();

    // Long receiver hold-off, sender never idles
    set_camera(640, 480, 10 << FB, 10 << FB, 46341, 46341, -30000, 30000);
    idle_on = 1'b0;
    hold_go = 1'b1;
    queue_random(250);
    drain();
    idle_on = 1'b1;

    // Random settings with random traffic
    for (int ph = 0; ph < 5; ph++) begin
      set_camera($urandom, $urandom_range(1, 4096), $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom);
      queue_random(220);
      drain();
    end

    $display("%0d sprite words sent, %0d projections checked (%0d degenerate)",
             n_sent, n_checked, n_degen);
    $display("over %0d camera settings, including a long output hold-off", 12);
    if (errors == 0 && expected_proj.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
